### src/tmds_pkg.sv
`default_nettype none
package tmds_pkg;

	localparam int ROWS_DEFAULT          = 3;
	localparam int COLS_DEFAULT          = 3;
	localparam int COUNTER_WIDTH_DEFAULT = 4;

	localparam int LIMIT_W     = 4;
	localparam int CFG_IDX_W   = 2;
	localparam int LED_W       = 2;

	localparam logic [LIMIT_W-1:0] LOWER_RESET = 4'd2;
	localparam logic [LIMIT_W-1:0] UPPER_RESET = 4'd6;
	localparam logic [LED_W-1:0]   LED_LAST    = 2'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LOWER_LIMIT = 2'd0,
		CFG_UPPER_LIMIT = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] lower;
		logic [LIMIT_W-1:0] upper;
	} limits_t;

endpackage
`default_nettype wire

### src/tmds_if.sv
`default_nettype none
interface tmds_in_if #(
	parameter int COLS = tmds_pkg::COLS_DEFAULT
);
	logic            valid;
	logic            ready;
	logic [COLS-1:0] column_samples;

	modport source (output valid, output column_samples, input ready);
	modport sink   (input valid, input column_samples, output ready);
endinterface

interface tmds_out_if #(
	parameter int COLS  = tmds_pkg::COLS_DEFAULT,
	parameter int ROW_W = 2,
	parameter int KEY_W = 4
);
	logic                       valid;
	logic                       ready;
	logic [ROW_W-1:0]           scanned_row;
	logic                       press_event;
	logic [KEY_W-1:0]           key_index;
	logic [tmds_pkg::LED_W-1:0] led_value;
	logic [COLS-1:0]            pressed_flags;

	modport source (
		output valid, output scanned_row, output press_event, output key_index,
		output led_value, output pressed_flags, input ready
	);
	modport sink (
		input valid, input scanned_row, input press_event, input key_index,
		input led_value, input pressed_flags, output ready
	);
endinterface

interface tmds_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [tmds_pkg::CFG_IDX_W-1:0] index;
	logic [tmds_pkg::LIMIT_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### src/tmds_cfg_regs.sv
`default_nettype none
module tmds_cfg_regs (
	input  wire logic         clk,
	input  wire logic         arst_n,
	tmds_cfg_if.sink          cfg,
	output tmds_pkg::limits_t limits
);

	tmds_pkg::limits_t limits_q;

	assign cfg.ready = 1'b1;
	assign limits    = limits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.lower <= tmds_pkg::LOWER_RESET;
			limits_q.upper <= tmds_pkg::UPPER_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				tmds_pkg::CFG_LOWER_LIMIT: limits_q.lower <= cfg.data;
				tmds_pkg::CFG_UPPER_LIMIT: limits_q.upper <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

### src/tmds_pad_cell.sv
`default_nettype none
module tmds_pad_cell #(
	parameter int COUNTER_WIDTH = tmds_pkg::COUNTER_WIDTH_DEFAULT
) (
	input  wire tmds_pkg::limits_t        limits,
	input  wire logic [COUNTER_WIDTH-1:0] cnt,
	input  wire logic                     pressed,
	input  wire logic                     touched,
	output logic      [COUNTER_WIDTH-1:0] cnt_next,
	output logic                          pressed_next,
	output logic                          press
);

	localparam int EW = ((COUNTER_WIDTH > tmds_pkg::LIMIT_W) ?
		COUNTER_WIDTH : tmds_pkg::LIMIT_W) + 2;

	logic signed [EW-1:0] v;
	logic signed [EW-1:0] lo;
	logic signed [EW-1:0] hi;
	logic                 held;

	always_comb begin
		lo = $signed(EW'(limits.lower));
		hi = $signed(EW'(limits.upper));
		v  = touched ? $signed(EW'(cnt) + EW'(1)) : $signed(EW'(cnt) - EW'(1));
		// lower clamp first, upper clamp wins on crossed limits
		if (v < lo) begin
			v = lo;
		end
		if (v > hi) begin
			v = hi;
		end
		cnt_next = v[COUNTER_WIDTH-1:0];

		held = pressed && (EW'(cnt_next) > EW'(limits.lower));
		press = !held && (EW'(cnt_next) >= EW'(limits.upper));
		pressed_next = held || press;
	end

endmodule
`default_nettype wire

### src/touch_matrix_debounce_scanner.sv
`default_nettype none
// Touch pad matrix scanner with integrating debounce and hysteresis.
// sample_in : one transfer per scan tick, carrying the column samples of the
//             row selected by an internal row counter (0 .. ROWS-1, wrapping).
// result_out: one transfer per accepted scan: scanned row, press event with
//             key index and advanced LED state, and the row's pressed flags.
// cfg       : register writes, index 0 lower limit, index 1 upper limit;
//             always ready, other indexes are dropped. Write only when idle.
// Path:    an accepted scan sits in the input register and its result is
//          loaded into the output register when the output register can
//          advance (empty, or its result taken by result_out).
// Throughput: one scan per cycle unless result_out stalls; the pad update is
//          a single pass over one row of counters between the two registers.
// Stall: when result_out is not ready the output register holds its result,
//          the input register holds one further scan, then sample_in.ready
//          drops until the result is taken.
// Reset: row counter 0, pad counters at the reset lower limit (2), all pads
//          released, LED states 0, limits 2 and 6, both registers empty.
module touch_matrix_debounce_scanner #(
	parameter int ROWS          = tmds_pkg::ROWS_DEFAULT,
	parameter int COLS          = tmds_pkg::COLS_DEFAULT,
	parameter int COUNTER_WIDTH = tmds_pkg::COUNTER_WIDTH_DEFAULT
) (
	input  wire logic clk,
	input  wire logic arst_n,
	tmds_in_if.sink   sample_in,
	tmds_out_if.source result_out,
	tmds_cfg_if.sink  cfg
);

	localparam int PADS  = ROWS * COLS;
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int KEY_W = (PADS > 1) ? $clog2(PADS) : 1;
	localparam int COL_W = (COLS > 1) ? $clog2(COLS) : 1;
	localparam int LW    = tmds_pkg::LED_W;

	tmds_pkg::limits_t limits;

	logic [COUNTER_WIDTH-1:0] cnt_q     [ROWS][COLS];
	logic                     pressed_q [ROWS][COLS];
	logic [LW-1:0]            led_q     [ROWS][COLS];
	logic [ROW_W-1:0]         row_q;

	logic                     valid_s1;
	logic [COLS-1:0]          samples_s1;

	logic                     out_valid_q;
	logic [ROW_W-1:0]         row_out_q;
	logic                     event_q;
	logic [KEY_W-1:0]         key_q;
	logic [LW-1:0]            led_out_q;
	logic [COLS-1:0]          flags_q;

	logic                     adv;
	logic                     fire;
	logic [ROW_W-1:0]         row_eff;
	logic [ROW_W-1:0]         row_nxt;
	logic [KEY_W-1:0]         row_base;
	logic [COUNTER_WIDTH-1:0] cnt_new [COLS];
	logic [COLS-1:0]          flags_new;
	logic [COLS-1:0]          press;
	logic                     ev;
	logic [COL_W-1:0]         sel;
	logic [LW-1:0]            led_cur;
	logic [LW-1:0]            led_new;

	tmds_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.limits (limits)
	);

	assign adv             = !out_valid_q || result_out.ready;
	assign fire            = valid_s1 && adv;
	assign sample_in.ready = !valid_s1 || adv;

	assign row_eff  = (32'(row_q) >= ROWS) ? '0 : row_q;
	assign row_nxt  = (32'(row_eff) + 1 >= ROWS) ? '0 : row_eff + ROW_W'(1);
	assign row_base = KEY_W'(row_eff) * KEY_W'(COLS);

	for (genvar c = 0; c < COLS; c++) begin : g_pad
		tmds_pad_cell #(
			.COUNTER_WIDTH (COUNTER_WIDTH)
		) u_pad (
			.limits       (limits),
			.cnt          (cnt_q[row_eff][c]),
			.pressed      (pressed_q[row_eff][c]),
			.touched      (samples_s1[c]),
			.cnt_next     (cnt_new[c]),
			.pressed_next (flags_new[c]),
			.press        (press[c])
		);
	end

	// highest column wins
	always_comb begin
		ev  = 1'b0;
		sel = '0;
		for (int c = 0; c < COLS; c++) begin
			if (press[c]) begin
				ev  = 1'b1;
				sel = COL_W'(c);
			end
		end
		led_cur = led_q[row_eff][sel];
		led_new = (led_cur >= tmds_pkg::LED_LAST) ? '0 : led_cur + LW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_in.ready) begin
			valid_s1 <= sample_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_in.ready && sample_in.valid) begin
			samples_s1 <= sample_in.column_samples;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			for (int r = 0; r < ROWS; r++) begin
				for (int c = 0; c < COLS; c++) begin
					cnt_q[r][c]     <= COUNTER_WIDTH'(tmds_pkg::LOWER_RESET);
					pressed_q[r][c] <= 1'b0;
					led_q[r][c]     <= '0;
				end
			end
		end else if (fire) begin
			row_q <= row_nxt;
			for (int c = 0; c < COLS; c++) begin
				cnt_q[row_eff][c]     <= cnt_new[c];
				pressed_q[row_eff][c] <= flags_new[c];
			end
			if (ev) begin
				led_q[row_eff][sel] <= led_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			row_out_q <= row_eff;
			event_q   <= ev;
			key_q     <= ev ? row_base + KEY_W'(sel) : '0;
			led_out_q <= ev ? led_new : '0;
			flags_q   <= flags_new;
		end
	end

	assign result_out.valid         = out_valid_q;
	assign result_out.scanned_row   = row_out_q;
	assign result_out.press_event   = event_q;
	assign result_out.key_index     = key_q;
	assign result_out.led_value     = led_out_q;
	assign result_out.pressed_flags = flags_q;

`ifndef SYNTHESIS
	a_event_led: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid && result_out.press_event |->
			result_out.led_value <= tmds_pkg::LED_LAST)
		else $error("press result with LED state out of range");

	a_quiet_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid && !result_out.press_event |->
			result_out.key_index == '0 && result_out.led_value == '0)
		else $error("key or LED set without press event");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid |-> 32'(result_out.scanned_row) < ROWS)
		else $error("scanned row out of range");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(samples_s1) && $stable(row_q))
		else $error("stalled scan lost from input register");
`endif

endmodule
`default_nettype wire
